// ===== design/sart_pkg.sv =====
// ----------------------------------------------------------------------------
// sart_pkg: shared types and codes for the sorted address range table
// Holds the command and status codes, the request and result words, and the
// entry and cell control types used by the table core and its cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sart_pkg;

    localparam logic [1:0] CMD_CLEAR  = 2'd0;
    localparam logic [1:0] CMD_INSERT = 2'd1;
    localparam logic [1:0] CMD_LOOKUP = 2'd2;

    localparam logic [2:0] STAT_CLEARED   = 3'd0;
    localparam logic [2:0] STAT_INSERTED  = 3'd1;
    localparam logic [2:0] STAT_DUPLICATE = 3'd2;
    localparam logic [2:0] STAT_FULL      = 3'd3;
    localparam logic [2:0] STAT_FOUND     = 3'd4;
    localparam logic [2:0] STAT_EMPTY     = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic        block_kind;
    } in_word_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [5:0]  entry_index;
        logic [15:0] region_start;
        logic        region_kind;
        logic [6:0]  entry_total;
    } out_word_t;

    typedef struct packed {
        logic [15:0] start;
        logic        kind;
    } entry_t;

    typedef struct packed {
        logic        cmp_en;
        logic        ins_en;
        logic [15:0] probe;
        entry_t      new_entry;
    } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/sart_cell.sv =====
// ----------------------------------------------------------------------------
// sart_cell: one slot of the sorted table
// Holds one region start and kind, compares it against the probe address,
// and on insert either keeps its entry, takes the new one, or shifts in the
// entry of its lower neighbor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sart_cell
    import sart_pkg::*;
(
    input  wire logic       clk,
    input  wire cell_ctrl_t ctrl,
    input  wire logic       cell_valid,
    input  wire logic       prev_lt,
    input  wire entry_t     prev_entry,
    output entry_t          entry,
    output logic            lt,
    output logic            le
);

    entry_t entry_reg;
    entry_t entry_next;
    logic   lt_reg;
    logic   lt_next;
    logic   le_reg;
    logic   le_next;

    always_comb
    begin
        lt_next    = lt_reg;
        le_next    = le_reg;
        entry_next = entry_reg;
        if (ctrl.cmp_en)
        begin
            lt_next = cell_valid && (entry_reg.start < ctrl.probe);
            le_next = cell_valid && (entry_reg.start <= ctrl.probe);
        end
        // slots at or above the insert point move up by one
        if (ctrl.ins_en && !lt_reg)
        begin
            entry_next = prev_lt ? ctrl.new_entry : prev_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lt_reg    <= lt_next;
        le_reg    <= le_next;
    end

    assign entry = entry_reg;
    assign lt    = lt_reg;
    assign le    = le_reg;

endmodule

`default_nettype wire

// ===== design/sorted_address_range_table_core.sv =====
// result: an accepted word passes the compare and execute states, then the
// done register gives its result strobe (done is high for one cycle)
// accept: a new word is taken only in the idle state, after the compare and
// execute steps that every word takes through the row of cells
// reset: clears the entry count and the control state; table slots hold
// no reset and are only read below the count
// ----------------------------------------------------------------------------
// sorted_address_range_table_core: sorted region start table with lookup
// A row of cells keeps region starts in ascending order; inserts shift the
// upper slots along the row, lookups find the range that holds an address.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sorted_address_range_table_core
    import sart_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire in_word_t request,
    output logic          busy,
    output logic          done,
    output out_word_t     result
);

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    typedef enum logic [2:0] {
        IDLE    = 3'b001,
        COMPARE = 3'b010,
        EXECUTE = 3'b100
    } state_t;

    state_t     state_reg;
    state_t     state_next;
    in_word_t   req_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic       done_reg;
    out_word_t  result_reg;
    out_word_t  result_next;

    cell_ctrl_t    ctrl;
    entry_t        cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_valid;
    logic [CAPACITY-1:0] lt;
    logic [CAPACITY-1:0] le;
    logic [CAPACITY-1:0] ins_hot;
    logic [CAPACITY-1:0] look_sel;

    logic             is_clear;
    logic             is_insert;
    logic             dup;
    logic             full;
    logic             ins_do;
    logic [IDX_W-1:0] ins_idx;
    logic [IDX_W-1:0] look_idx;
    entry_t           look_entry;
    logic [IDX_W+5:0] idx_wide;
    logic [CNT_W+6:0] cnt_wide;

    assign is_clear  = (req_reg.command == CMD_CLEAR);
    assign is_insert = (req_reg.command == CMD_INSERT);
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign dup       = |(le & ~lt);
    assign ins_do    = (state_reg == EXECUTE) && is_insert && !dup && !full;

    assign ctrl.cmp_en           = (state_reg == COMPARE);
    assign ctrl.ins_en           = ins_do;
    assign ctrl.probe            = req_reg.address;
    assign ctrl.new_entry.start  = req_reg.address;
    assign ctrl.new_entry.kind   = req_reg.block_kind;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic   prev_lt;
            entry_t prev_entry;
            if (gi == 0)
            begin : g_first
                assign prev_lt    = 1'b1;
                assign prev_entry = ctrl.new_entry;
            end
            else
            begin : g_rest
                assign prev_lt    = lt[gi-1];
                assign prev_entry = cell_entry[gi-1];
            end
            assign cell_valid[gi] = (CNT_W'(gi) < count_reg);
            sart_cell u_cell (
                .clk        (clk),
                .ctrl       (ctrl),
                .cell_valid (cell_valid[gi]),
                .prev_lt    (prev_lt),
                .prev_entry (prev_entry),
                .entry      (cell_entry[gi]),
                .lt         (lt[gi]),
                .le         (le[gi])
            );
        end
    endgenerate

    // insert point is the edge of the less-than thermometer, lookup picks
    // the last slot at or below the address, or the top occupied slot if none
    always_comb
    begin
        ins_idx    = '0;
        look_idx   = '0;
        look_entry = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            ins_hot[i] = ((i == 0) ? 1'b1 : lt[(i == 0) ? 0 : i-1]) && !lt[i];
            if (le[0])
            begin
                look_sel[i] = le[i] && ((i == CAPACITY-1) ? 1'b1
                                        : !le[(i == CAPACITY-1) ? i : i+1]);
            end
            else
            begin
                look_sel[i] = (count_reg == CNT_W'(i + 1));
            end
            if (ins_hot[i])
            begin
                ins_idx = ins_idx | IDX_W'(i);
            end
            if (look_sel[i])
            begin
                look_idx   = look_idx | IDX_W'(i);
                look_entry = look_entry | cell_entry[i];
            end
        end
    end

    always_comb
    begin
        count_next  = count_reg;
        result_next = '0;
        idx_wide    = '0;
        if (is_clear)
        begin
            count_next         = '0;
            result_next.status = STAT_CLEARED;
        end
        else if (is_insert)
        begin
            if (dup)
            begin
                result_next.status = STAT_DUPLICATE;
            end
            else if (full)
            begin
                result_next.status = STAT_FULL;
            end
            else
            begin
                count_next              = count_reg + CNT_W'(1);
                idx_wide                = {6'd0, ins_idx};
                result_next.status      = STAT_INSERTED;
                result_next.entry_index = idx_wide[5:0];
            end
        end
        else if (count_reg == '0)
        begin
            result_next.status = STAT_EMPTY;
        end
        else
        begin
            idx_wide                 = {6'd0, look_idx};
            result_next.status       = STAT_FOUND;
            result_next.entry_index  = idx_wide[5:0];
            result_next.region_start = look_entry.start;
            result_next.region_kind  = look_entry.kind;
        end
        cnt_wide                = {7'd0, count_next};
        result_next.entry_total = cnt_wide[6:0];
    end

    always_comb
    begin
        case (state_reg)
            IDLE:    state_next = start ? COMPARE : IDLE;
            COMPARE: state_next = EXECUTE;
            EXECUTE: state_next = IDLE;
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == EXECUTE);
            if (state_reg == EXECUTE)
            begin
                count_reg <= count_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == IDLE && start)
        begin
            req_reg <= request;
        end
        if (state_reg == EXECUTE)
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = (state_reg != IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == EXECUTE))
        else $error("result strobe without execute step");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && !done))
        else $error("accepted word did not raise busy");

    a_ins_point: assert property (@(posedge clk) disable iff (!rst_n)
        ins_do |-> $onehot(ins_hot))
        else $error("insert point not unique");

    a_look_sel: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == EXECUTE && req_reg.command[1] && count_reg != '0)
            |-> $onehot(look_sel))
        else $error("lookup select not unique");

endmodule

`default_nettype wire
